/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, held off while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication, held off while reset is low
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

/* rtl/npc_pkg.sv */
package npc_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
    localparam int COMP_W          = 8;
    localparam int IDX_W           = 8;
    localparam int SQ_W            = 2 * COMP_W;
    localparam int DIST_W          = 18;
    localparam int ENTRY_W         = 3 * COMP_W;

    localparam logic [CNT_W-1:0]  SCAN_END   = CNT_W'(PALETTE_ENTRIES);
    localparam logic [IDX_W:0]    LOAD_LIMIT = (IDX_W + 1)'(PALETTE_ENTRIES);
    localparam logic [DIST_W-1:0] MAX_DIST   = DIST_W'(195075);

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [IDX_W-1:0]  entry_index;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic              last_pixel;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]  color_index;
        logic [DIST_W-1:0] best_distance;
        logic              last_out;
    } t_out_item;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } t_rgb;

    // travels alongside an entry through the distance pipeline
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] idx;
    } t_tag;

endpackage

/* rtl/npc_ram.sv */
module npc_ram #(
    parameter int  WIDTH = 24,
    parameter int  DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/npc_dist.sv */
// two-stage squared distance: per-channel squares, then the sum
module npc_dist (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  npc_pkg::t_rgb              i_entry,
    input  npc_pkg::t_rgb              i_pixel,
    input  npc_pkg::t_tag              i_tag,
    output logic [npc_pkg::DIST_W-1:0] o_dist,
    output npc_pkg::t_tag              o_tag
);

    logic [npc_pkg::COMP_W-1:0] w_dr, w_dg, w_db;
    logic [npc_pkg::SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;
    npc_pkg::t_tag              r_tag1, r_tag2;
    logic [npc_pkg::DIST_W-1:0] r_dist;

    assign w_dr = (i_entry.red >= i_pixel.red) ? i_entry.red - i_pixel.red
                                               : i_pixel.red - i_entry.red;
    assign w_dg = (i_entry.green >= i_pixel.green) ? i_entry.green - i_pixel.green
                                                   : i_pixel.green - i_entry.green;
    assign w_db = (i_entry.blue >= i_pixel.blue) ? i_entry.blue - i_pixel.blue
                                                 : i_pixel.blue - i_entry.blue;

    always_ff @(posedge i_clk) begin
        r_sq_r <= npc_pkg::SQ_W'(w_dr) * npc_pkg::SQ_W'(w_dr);
        r_sq_g <= npc_pkg::SQ_W'(w_dg) * npc_pkg::SQ_W'(w_dg);
        r_sq_b <= npc_pkg::SQ_W'(w_db) * npc_pkg::SQ_W'(w_db);
        r_dist <= npc_pkg::DIST_W'(r_sq_r) + npc_pkg::DIST_W'(r_sq_g)
                + npc_pkg::DIST_W'(r_sq_b);
        r_tag1.idx <= i_tag.idx;
        r_tag2.idx <= r_tag1.idx;
        if (!i_rst_n) begin
            r_tag1.vld <= 1'b0;
            r_tag2.vld <= 1'b0;
        end else begin
            r_tag1.vld <= i_tag.vld;
            r_tag2.vld <= r_tag1.vld;
        end
    end

    assign o_dist = r_dist;
    assign o_tag  = r_tag2;

endmodule

/* rtl/nearest_palette_color.sv */
// Nearest palette color. A load item (cmd = load) writes one 24-bit palette
// entry (red, green, blue) at entry_index; an index at or beyond
// PALETTE_ENTRIES is dropped and no result comes back for any load.
// A pixel item walks the whole palette: one entry is read per cycle from the
// palette RAM's single read port into a squared-distance unit and a compare
// stage, so a pixel holds the input side until the whole palette is read and
// the pipeline has drained, and also while the previous result still waits in
// the output register; the RAM read port is what sets the scan length. The
// result carries the lowest index with the smallest squared distance, that
// distance, and the pixel's last mark. The finished result sits in an output
// register, so load items are taken while it waits.
// The palette is not cleared at reset: every entry must be loaded before the
// first pixel, otherwise the fields of the result are meaningless.
`include "assert_macros.svh"

module nearest_palette_color (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  npc_pkg::t_in_item  i_data,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output npc_pkg::t_out_item o_data
);

    // one-hot sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                           r_state, n_state;
    logic [npc_pkg::CNT_W-1:0]        r_addr, n_addr;
    npc_pkg::t_rgb                    r_pix;
    logic                             r_last;
    npc_pkg::t_tag                    r_rd_tag;
    logic [npc_pkg::ENTRY_W-1:0]      w_rdata;
    logic [npc_pkg::DIST_W-1:0]       w_dist;
    npc_pkg::t_tag                    w_dist_tag;
    logic [npc_pkg::DIST_W-1:0]       r_best_d;
    logic [npc_pkg::ADDR_W-1:0]       r_best_idx;
    logic                             r_have;
    logic                             r_out_vld;
    npc_pkg::t_out_item               r_out;

    logic w_in_acc;
    logic w_load_we;
    logic w_issue;
    logic w_scan_done;
    logic w_take;

    assign o_ready  = (r_state == S_IDLE);
    assign w_in_acc = i_valid && o_ready;

    // load writes only inside the palette depth
    assign w_load_we = w_in_acc && (i_data.cmd == npc_pkg::CMD_LOAD)
                    && ({1'b0, i_data.entry_index} < npc_pkg::LOAD_LIMIT);

    // one palette read per cycle until every entry is issued
    assign w_issue = (r_state == S_SCAN) && (r_addr != npc_pkg::SCAN_END);

    // pipeline drained and output register free to take the result
    assign w_scan_done = (r_state == S_SCAN) && !w_issue && !r_rd_tag.vld
                      && !w_dist_tag.vld && (!r_out_vld || i_ready);

    // strict compare keeps the lowest index among equal distances
    assign w_take = w_dist_tag.vld && (!r_have || (w_dist < r_best_d));

    npc_ram #(
        .WIDTH (npc_pkg::ENTRY_W),
        .DEPTH (npc_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (i_data.entry_index[npc_pkg::ADDR_W-1:0]),
        .i_wdata ({i_data.red, i_data.green, i_data.blue}),
        .i_raddr (r_addr[npc_pkg::ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    npc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (npc_pkg::t_rgb'(w_rdata)),
        .i_pixel (r_pix),
        .i_tag   (r_rd_tag),
        .o_dist  (w_dist),
        .o_tag   (w_dist_tag)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_data.cmd == npc_pkg::CMD_PIXEL)) begin
                    n_state = S_SCAN;
                    n_addr  = '0;
                end
            end
            S_SCAN: begin
                if (w_issue) begin
                    n_addr = r_addr + 1'b1;
                end
                if (w_scan_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        // read tag follows the address issued to the ram
        r_rd_tag.idx <= r_addr[npc_pkg::ADDR_W-1:0];
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_addr       <= '0;
            r_rd_tag.vld <= 1'b0;
            r_have       <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_rd_tag.vld <= w_issue;
            // new pixel starts with no best yet
            if (w_in_acc && (i_data.cmd == npc_pkg::CMD_PIXEL)) begin
                r_have <= 1'b0;
            end else if (w_take) begin
                r_have <= 1'b1;
            end
            if (w_scan_done) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_data.cmd == npc_pkg::CMD_PIXEL)) begin
            r_pix.red   <= i_data.red;
            r_pix.green <= i_data.green;
            r_pix.blue  <= i_data.blue;
            r_last      <= i_data.last_pixel;
        end
        if (w_take) begin
            r_best_d   <= w_dist;
            r_best_idx <= w_dist_tag.idx;
        end
        if (w_scan_done) begin
            r_out.color_index   <= npc_pkg::IDX_W'(r_best_idx);
            r_out.best_distance <= r_best_d;
            r_out.last_out      <= r_last;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    `ASSERT_CLK(a_addr_bound, r_addr <= npc_pkg::SCAN_END,
        "scan address ran past the palette")
    `ASSERT_IMPLY(a_best_bound, r_have, r_best_d <= npc_pkg::MAX_DIST,
        "best distance exceeds the largest possible distance")
    `ASSERT_CLK(a_pixel_scan, (w_in_acc && (i_data.cmd == npc_pkg::CMD_PIXEL))
        |=> ((r_state == S_SCAN) && (r_addr == '0)),
        "pixel item did not start a palette scan")
    `ASSERT_IMPLY(a_done_drained, w_scan_done, r_have && !w_dist_tag.vld,
        "result taken before the distance pipeline drained")

endmodule

/* tb/palette_match_checker.sv */
`timescale 1ns / 1ps

module palette_match_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  npc_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  npc_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    npc_pkg::t_rgb      shadow_palette [npc_pkg::PALETTE_ENTRIES];
    npc_pkg::t_out_item expected_matches [$];
    npc_pkg::t_out_item want_match;

    // full palette sweep, strict compare keeps the lowest index on ties
    function automatic npc_pkg::t_out_item nearest_match(input npc_pkg::t_in_item px);
        npc_pkg::t_out_item res;
        int        best_dist;
        int        sq_dist;
        int        dr;
        int        dg;
        int        db;
        res       = '0;
        best_dist = 1 << 30;
        for (int j = 0; j < npc_pkg::PALETTE_ENTRIES; j++) begin
            dr      = int'(shadow_palette[j].red) - int'(px.red);
            dg      = int'(shadow_palette[j].green) - int'(px.green);
            db      = int'(shadow_palette[j].blue) - int'(px.blue);
            sq_dist = dr * dr + dg * dg + db * db;
            if (sq_dist < best_dist) begin
                best_dist         = sq_dist;
                res.color_index   = npc_pkg::IDX_W'(j);
                res.best_distance = npc_pkg::DIST_W'(best_dist);
            end
        end
        res.last_out = px.last_pixel;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_matches.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            // result side first: a pixel taken at this edge cannot finish at it
            if (i_out_valid && i_out_ready) begin
                if (expected_matches.size() == 0) begin
                    $error("unexpected result: color_index %0d best_distance %0d last_out %0b",
                           i_out_item.color_index, i_out_item.best_distance,
                           i_out_item.last_out);
                    o_fail_count++;
                end else begin
                    want_match = expected_matches.pop_front();
                    o_checked++;
                    if (i_out_item.color_index !== want_match.color_index) begin
                        $error("color_index mismatch: expected %0d, actual %0d",
                               want_match.color_index, i_out_item.color_index);
                        o_fail_count++;
                    end
                    if (i_out_item.best_distance !== want_match.best_distance) begin
                        $error("best_distance mismatch: expected %0d, actual %0d",
                               want_match.best_distance, i_out_item.best_distance);
                        o_fail_count++;
                    end
                    if (i_out_item.last_out !== want_match.last_out) begin
                        $error("last_out mismatch: expected %0b, actual %0b",
                               want_match.last_out, i_out_item.last_out);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_item.cmd == npc_pkg::CMD_LOAD) begin
                    if (int'(i_in_item.entry_index) < npc_pkg::PALETTE_ENTRIES)
                        shadow_palette[i_in_item.entry_index] =
                            {i_in_item.red, i_in_item.green, i_in_item.blue};
                end else begin
                    expected_matches.push_back(nearest_match(i_in_item));
                end
            end
        end
        o_pending = expected_matches.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF        = 5;
    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int LONG_HOLD       = 3000;  // result side held off this long once
    localparam int DRAIN_CYCLES    = 300;   // a little over one full palette sweep
    localparam int NUM_PHASES      = 4;
    localparam int MIXED_PER_PHASE = 290;

    localparam npc_pkg::t_rgb BLACK = 24'h000000;
    localparam npc_pkg::t_rgb WHITE = 24'hFFFFFF;
    localparam npc_pkg::t_rgb RED   = 24'hFF0000;
    localparam npc_pkg::t_rgb GREEN = 24'h00FF00;
    localparam npc_pkg::t_rgb BLUE  = 24'h0000FF;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    npc_pkg::t_in_item  in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    npc_pkg::t_out_item out_item;

    // handshake pressure knobs for the current phase
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic hold_req     = 1'b0;
    logic hold_taken   = 1'b0;
    int   hold_left    = 0;

    int   cycle_count  = 0;
    int   loads_sent   = 0;
    int   pixels_sent  = 0;
    int   fail_count;
    int   pending;
    int   checked;

    // local copy of the palette, only used to aim pixels at or near stored colors
    npc_pkg::t_rgb palette_copy [npc_pkg::PALETTE_ENTRIES];

    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    nearest_palette_color dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_item)
    );

    palette_match_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // result side: random stalls, plus one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // offer one item, with random idle cycles ahead of it, and hold it until taken
    task automatic send_item(input npc_pkg::t_in_item item);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_entry(input logic [7:0] idx, input npc_pkg::t_rgb color,
                               input logic last);
        npc_pkg::t_in_item item;
        item.cmd         = npc_pkg::CMD_LOAD;
        item.entry_index = idx;
        item.red         = color.red;
        item.green       = color.green;
        item.blue        = color.blue;
        item.last_pixel  = last;   // ignored on a palette write
        palette_copy[idx] = color;
        send_item(item);
        loads_sent++;
    endtask

    task automatic quantize_pixel(input npc_pkg::t_rgb color, input logic last,
                                  input logic [7:0] junk);
        npc_pkg::t_in_item item;
        item.cmd         = npc_pkg::CMD_PIXEL;
        item.entry_index = junk;   // ignored on a pixel
        item.red         = color.red;
        item.green       = color.green;
        item.blue        = color.blue;
        item.last_pixel  = last;
        send_item(item);
        pixels_sent++;
    endtask

    function automatic npc_pkg::t_rgb random_color();
        return npc_pkg::t_rgb'(24'($urandom));
    endfunction

    // small offset around a component, clamped to the byte range
    function automatic logic [7:0] nudge(input logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(8)) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    initial begin : stimulus
        npc_pkg::t_rgb swatch [4];
        npc_pkg::t_rgb base;
        npc_pkg::t_rgb color;
        int            pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // whole palette black first: no pixel may ever reach an unwritten entry
        for (int e = 0; e < npc_pkg::PALETTE_ENTRIES; e++)
            write_entry(8'(e), BLACK, 1'(e));

        // directed: worst distance, all-tie palette, ties between written colors,
        // unsigned extremes of each channel
        quantize_pixel(WHITE, 1'b1, 8'hFF);
        quantize_pixel(BLACK, 1'b0, 8'h00);
        write_entry(8'd255, WHITE, 1'b1);
        quantize_pixel(WHITE, 1'b0, 8'hA5);
        write_entry(8'd128, WHITE, 1'b0);
        quantize_pixel(WHITE, 1'b1, 8'h5A);
        write_entry(8'd0, RED, 1'b1);
        quantize_pixel(RED, 1'b0, 8'h00);
        quantize_pixel(GREEN, 1'b1, 8'hFF);
        write_entry(8'd1, BLUE, 1'b0);
        quantize_pixel(24'h0000FE, 1'b0, 8'h01);
        quantize_pixel(24'h808080, 1'b1, 8'h80);
        quantize_pixel(24'h7F7F7F, 1'b0, 8'h7F);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 66; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 66; end
                default: begin tx_idle_pct = 36; rx_stall_pct <= 36; end
            endcase

            // fresh palette: fully random, or a handful of colors so ties are common
            if (phase == 0) begin
                for (int e = 0; e < npc_pkg::PALETTE_ENTRIES; e++)
                    write_entry(8'(e), random_color(), 1'($urandom));
            end else if (phase == 2) begin
                for (int s = 0; s < 4; s++) swatch[s] = random_color();
                for (int e = npc_pkg::PALETTE_ENTRIES - 1; e >= 0; e--)
                    write_entry(8'(e), swatch[$urandom_range(3)], 1'($urandom));
            end

            // long result hold-off while pixels keep coming, fills the block up
            if (phase == 0) hold_req <= 1'b1;

            for (int n = 0; n < MIXED_PER_PHASE; n++) begin
                pick = int'($urandom_range(99));
                if (phase == 0 && n < 12) pick = 99;
                if (pick < 35) begin
                    write_entry(8'($urandom), random_color(), 1'($urandom));
                end else if (pick < 60) begin
                    quantize_pixel(random_color(), 1'($urandom), 8'($urandom));
                end else if (pick < 85) begin
                    // near a stored color
                    base  = palette_copy[8'($urandom)];
                    color = {nudge(base.red), nudge(base.green), nudge(base.blue)};
                    quantize_pixel(color, 1'($urandom), 8'($urandom));
                end else begin
                    // exact hit, zero distance
                    quantize_pixel(palette_copy[8'($urandom)], 1'($urandom), 8'($urandom));
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d items (%0d palette writes, %0d pixels), %0d results compared",
                 loads_sent + pixels_sent, loads_sent, pixels_sent, checked);
        $display("run: four idle/stall profiles plus a %0d-cycle result hold-off",
                 LONG_HOLD);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
